FILE: design/u8lec_pkg.sv
// Shared types and constants for the UTF-8 line ending counter.
`timescale 1ns / 1ps

package u8lec_pkg;

   localparam int COUNT_BITS     = 48;  // default counter width
   localparam int MAX_COUNT_BITS = 64;
   localparam int CNT_OUT_BITS   = 48;  // width of the count fields on the result
   localparam int CP_BITS        = 21;
   localparam int SEQ_BITS       = 3;
   localparam int REM_BITS       = 2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_START = 3'd1;
   localparam logic [2:0] STATUS_PREMATURE = 3'd2;
   localparam logic [2:0] STATUS_BAD_CONT  = 3'd3;
   localparam logic [2:0] STATUS_RANGE     = 3'd4;

   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [CP_BITS-1:0] CP_LIMIT = 21'h10FFFF;
   localparam logic [CP_BITS-1:0] CH_CR    = 21'h00000D;
   localparam logic [CP_BITS-1:0] CH_LF    = 21'h00000A;

   // Decoder controls toward the counters and the result register
   typedef struct packed {
      logic                emit;
      logic [2:0]          status;
      logic [SEQ_BITS-1:0] index;
      logic                inc_char;
      logic                inc_lf;
      logic                inc_cr;
      logic                inc_crlf;
      logic                clear;
   } dec_ctl_type;

endpackage

FILE: design/u8lec_req_if.sv
// Request channel: one byte or end of stream marker per request.
`timescale 1ns / 1ps

interface u8lec_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

FILE: design/u8lec_rsp_if.sv
// Result channel: status, failing byte position and the four counts.
`timescale 1ns / 1ps

interface u8lec_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          status;
   logic [2:0]                          bad_byte_index;
   logic [u8lec_pkg::CNT_OUT_BITS-1:0]  char_count;
   logic [u8lec_pkg::CNT_OUT_BITS-1:0]  lf_count;
   logic [u8lec_pkg::CNT_OUT_BITS-1:0]  cr_count;
   logic [u8lec_pkg::CNT_OUT_BITS-1:0]  crlf_count;

   modport source (output valid, output status, output bad_byte_index, output char_count,
                   output lf_count, output cr_count, output crlf_count, input ready);
   modport sink   (input valid, input status, input bad_byte_index, input char_count,
                   input lf_count, input cr_count, input crlf_count, output ready);
endinterface

FILE: design/u8lec_counter.sv
// Saturating event counter with synchronous clear.
`timescale 1ns / 1ps

module u8lec_counter #(
   parameter int WIDTH = u8lec_pkg::COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             inc,
   input  logic             clear,
   output logic [WIDTH-1:0] value_upd   // value after this request's increment
);

   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;

   always_comb begin
      value_upd = count_ff;
      if (inc && (count_ff != {WIDTH{1'b1}})) begin
         value_upd = count_ff + {{(WIDTH-1){1'b0}}, 1'b1};
      end
      count_in = clear ? '0 : value_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/u8lec_decoder.sv
// UTF-8 sequence decoder and line ending classifier.
`timescale 1ns / 1ps

module u8lec_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   action,
   input  logic [7:0]             data_byte,
   output u8lec_pkg::dec_ctl_type ctl
);

   logic [u8lec_pkg::REM_BITS-1:0] remain_ff, remain_in;
   logic [u8lec_pkg::SEQ_BITS-1:0] seq_ff, seq_in;
   logic [u8lec_pkg::CP_BITS-1:0]  cp_ff, cp_in;
   logic                           pending_cr_ff, pending_cr_in;
   logic                           failed_ff, failed_in;

   logic                           do_count;
   logic [u8lec_pkg::CP_BITS-1:0]  count_cp;
   logic [u8lec_pkg::CP_BITS-1:0]  cp_cont;
   logic [u8lec_pkg::SEQ_BITS-1:0] seq_inc;
   logic [u8lec_pkg::REM_BITS-1:0] remain_dec;

   assign cp_cont    = {cp_ff[u8lec_pkg::CP_BITS-7:0], data_byte[5:0]};
   assign seq_inc    = seq_ff + {{(u8lec_pkg::SEQ_BITS-1){1'b0}}, 1'b1};
   assign remain_dec = remain_ff - {{(u8lec_pkg::REM_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      remain_in     = remain_ff;
      seq_in        = seq_ff;
      cp_in         = cp_ff;
      pending_cr_in = pending_cr_ff;
      failed_in     = failed_ff;
      ctl           = '0;
      do_count      = 1'b0;
      count_cp      = '0;

      if (fire) begin
         if (action == u8lec_pkg::ACTION_END) begin
            if (!failed_ff) begin
               ctl.emit = 1'b1;
               if (remain_ff != '0) begin
                  ctl.status = u8lec_pkg::STATUS_PREMATURE;
                  ctl.index  = seq_inc;
               end else begin
                  ctl.status = u8lec_pkg::STATUS_OK;
                  ctl.inc_cr = pending_cr_ff;   // trailing CR is a lone CR
               end
            end
            ctl.clear     = 1'b1;
            remain_in     = '0;
            seq_in        = '0;
            cp_in         = '0;
            pending_cr_in = 1'b0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            if (remain_ff == '0) begin
               if (!data_byte[7]) begin
                  do_count = 1'b1;
                  count_cp = {{(u8lec_pkg::CP_BITS-8){1'b0}}, data_byte};
               end else if (data_byte[7:5] == 3'b110) begin
                  cp_in     = {{(u8lec_pkg::CP_BITS-5){1'b0}}, data_byte[4:0]};
                  remain_in = 2'd1;
                  seq_in    = 3'd1;
               end else if (data_byte[7:4] == 4'b1110) begin
                  cp_in     = {{(u8lec_pkg::CP_BITS-4){1'b0}}, data_byte[3:0]};
                  remain_in = 2'd2;
                  seq_in    = 3'd1;
               end else if (data_byte[7:3] == 5'b11110) begin
                  cp_in     = {{(u8lec_pkg::CP_BITS-3){1'b0}}, data_byte[2:0]};
                  remain_in = 2'd3;
                  seq_in    = 3'd1;
               end else begin
                  ctl.emit   = 1'b1;
                  ctl.status = u8lec_pkg::STATUS_BAD_START;
                  ctl.index  = 3'd1;
                  failed_in  = 1'b1;
               end
            end else if (data_byte[7:6] != 2'b10) begin
               ctl.emit   = 1'b1;
               ctl.status = u8lec_pkg::STATUS_BAD_CONT;
               ctl.index  = seq_inc;
               failed_in  = 1'b1;
               remain_in  = '0;
               seq_in     = '0;
               cp_in      = '0;
            end else if (remain_dec != '0) begin
               cp_in     = cp_cont;
               seq_in    = seq_inc;
               remain_in = remain_dec;
            end else begin
               remain_in = '0;
               seq_in    = '0;
               cp_in     = '0;
               if (cp_cont > u8lec_pkg::CP_LIMIT) begin
                  ctl.emit   = 1'b1;
                  ctl.status = u8lec_pkg::STATUS_RANGE;
                  ctl.index  = seq_inc;
                  failed_in  = 1'b1;
               end else begin
                  do_count = 1'b1;
                  count_cp = cp_cont;
               end
            end
         end
      end

      // A CR waits for the next character to tell CR from CRLF
      if (do_count) begin
         ctl.inc_char = 1'b1;
         if (count_cp == u8lec_pkg::CH_CR) begin
            ctl.inc_cr    = pending_cr_ff;
            pending_cr_in = 1'b1;
         end else if (count_cp == u8lec_pkg::CH_LF) begin
            ctl.inc_crlf  = pending_cr_ff;
            ctl.inc_lf    = !pending_cr_ff;
            pending_cr_in = 1'b0;
         end else begin
            ctl.inc_cr    = pending_cr_ff;
            pending_cr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff     <= '0;
         seq_ff        <= '0;
         cp_ff         <= '0;
         pending_cr_ff <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         remain_ff     <= remain_in;
         seq_ff        <= seq_in;
         cp_ff         <= cp_in;
         pending_cr_ff <= pending_cr_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

FILE: design/utf8_line_ending_counter.sv
// Top level: UTF-8 byte stream decoder with character and line ending counts.
// Path: an accepted request is held in the input register; the result register loads
//   when the decoder fires on it (input register, then result register).
// Throughput: one byte per cycle; ready drops only while both registers hold an item
//   and the waiting result is not taken.
// Reset clears decoder state, counters and both valid flags; no clearing pass.
`timescale 1ns / 1ps

module utf8_line_ending_counter #(
   parameter int COUNT_BITS = u8lec_pkg::COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   u8lec_req_if.sink   req_chan,
   u8lec_rsp_if.source rsp_chan
);

   localparam int OUT_BITS = u8lec_pkg::CNT_OUT_BITS;

   logic       in_valid_ff;
   logic       action_ff;
   logic [7:0] byte_ff;
   logic       advance;

   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            status_ff;
   logic [2:0]            index_ff;
   logic [OUT_BITS-1:0]   char_ff, lf_ff, cr_ff, crlf_ff;

   u8lec_pkg::dec_ctl_type ctl;
   logic [COUNT_BITS-1:0]  char_upd, lf_upd, cr_upd, crlf_upd;
   logic [u8lec_pkg::MAX_COUNT_BITS-1:0] char_wide, lf_wide, cr_wide, crlf_wide;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         action_ff <= req_chan.action;
         byte_ff   <= req_chan.data_byte;
      end
   end

   u8lec_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .action    (action_ff),
      .data_byte (byte_ff),
      .ctl       (ctl)
   );

   u8lec_counter #(.WIDTH(COUNT_BITS)) u_char_cnt (
      .clock(clock), .reset(reset), .inc(ctl.inc_char), .clear(ctl.clear),
      .value_upd(char_upd));
   u8lec_counter #(.WIDTH(COUNT_BITS)) u_lf_cnt (
      .clock(clock), .reset(reset), .inc(ctl.inc_lf), .clear(ctl.clear),
      .value_upd(lf_upd));
   u8lec_counter #(.WIDTH(COUNT_BITS)) u_cr_cnt (
      .clock(clock), .reset(reset), .inc(ctl.inc_cr), .clear(ctl.clear),
      .value_upd(cr_upd));
   u8lec_counter #(.WIDTH(COUNT_BITS)) u_crlf_cnt (
      .clock(clock), .reset(reset), .inc(ctl.inc_crlf), .clear(ctl.clear),
      .value_upd(crlf_upd));

   // Counters of any width map onto the fixed result fields
   assign char_wide = u8lec_pkg::MAX_COUNT_BITS'(char_upd);
   assign lf_wide   = u8lec_pkg::MAX_COUNT_BITS'(lf_upd);
   assign cr_wide   = u8lec_pkg::MAX_COUNT_BITS'(cr_upd);
   assign crlf_wide = u8lec_pkg::MAX_COUNT_BITS'(crlf_upd);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = ctl.emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctl.emit) begin
         status_ff <= ctl.status;
         index_ff  <= ctl.index;
         char_ff   <= char_wide[OUT_BITS-1:0];
         lf_ff     <= lf_wide[OUT_BITS-1:0];
         cr_ff     <= cr_wide[OUT_BITS-1:0];
         crlf_ff   <= crlf_wide[OUT_BITS-1:0];
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.bad_byte_index = index_ff;
   assign rsp_chan.char_count     = char_ff;
   assign rsp_chan.lf_count       = lf_ff;
   assign rsp_chan.cr_count       = cr_ff;
   assign rsp_chan.crlf_count     = crlf_ff;

endmodule

FILE: design/u8lec_checker.sv
// Port-level checks for the UTF-8 line ending counter, bound to the top level.
`timescale 1ns / 1ps

module u8lec_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [2:0] rsp_index
);

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_index))
      else $error("result dropped or changed while stalled");

   // ok results carry no byte position, error results always do
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == u8lec_pkg::STATUS_OK) == (rsp_index == 3'd0)))
      else $error("status and byte position disagree");

   // out of range only ever flags the fourth byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == u8lec_pkg::STATUS_RANGE) |-> rsp_index == 3'd4)
      else $error("out of range at wrong byte position");

   // no result rises without an earlier accepted request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without request");

endmodule

bind utf8_line_ending_counter u8lec_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_index  (rsp_chan.bad_byte_index)
);
